FILE: hw/rtl/hsm_pkg.sv
`default_nettype none

package hsm_pkg;

    // Pattern store held by the register file (fixed by the register layout)
    localparam int PAT_BYTES   = 32;
    localparam int PAT_IDX_W   = 5;
    localparam int LEN_CFG_W   = 6;

    // Defaults for the top-level parameters
    localparam int PATTERN_MAX_DEF   = 32;
    localparam int POSITION_BITS_DEF = 20;

    // Result field
    localparam int OUT_W = 20;

    // Register port
    localparam int APB_AW      = 6;
    localparam int APB_DW      = 64;
    localparam int REG_IDX_LSB = 3;
    localparam int REG_IDX_W   = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_LENGTH        = 3'd0,
        REG_PAT_LOW       = 3'd1,
        REG_PAT_MID_LOW   = 3'd2,
        REG_PAT_MID_HIGH  = 3'd3,
        REG_PAT_HIGH      = 3'd4
    } t_reg_idx;

    typedef logic [PAT_BYTES-1:0][7:0] t_pattern;

    typedef struct packed {
        logic                 restart;     // length written this cycle
        logic [LEN_CFG_W-1:0] new_length;  // value being written
        logic [LEN_CFG_W-1:0] length;      // current register value
    } t_cfg;

endpackage

`default_nettype wire

FILE: hw/rtl/hsm_regs.sv
`default_nettype none

module hsm_regs
    import hsm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg,
    output t_pattern               o_pattern
);

    logic [LEN_CFG_W-1:0] r_len;
    t_pattern             r_pat;
    logic                 wr_en;
    t_reg_idx             reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[REG_IDX_LSB +: REG_IDX_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_pat <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_LENGTH:       r_len         <= pwdata[LEN_CFG_W-1:0];
                REG_PAT_LOW:      r_pat[7:0]    <= pwdata;
                REG_PAT_MID_LOW:  r_pat[15:8]   <= pwdata;
                REG_PAT_MID_HIGH: r_pat[23:16]  <= pwdata;
                REG_PAT_HIGH:     r_pat[31:24]  <= pwdata;
                default: ;  // drop writes to unmapped addresses
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_LENGTH:       prdata = {{(APB_DW-LEN_CFG_W){1'b0}}, r_len};
            REG_PAT_LOW:      prdata = r_pat[7:0];
            REG_PAT_MID_LOW:  prdata = r_pat[15:8];
            REG_PAT_MID_HIGH: prdata = r_pat[23:16];
            REG_PAT_HIGH:     prdata = r_pat[31:24];
            default:          prdata = '0;
        endcase
    end

    assign o_cfg.restart    = wr_en && (reg_idx == REG_LENGTH);
    assign o_cfg.new_length = pwdata[LEN_CFG_W-1:0];
    assign o_cfg.length     = r_len;
    assign o_pattern        = r_pat;

endmodule

`default_nettype wire

FILE: hw/rtl/horspool_string_match.sv
`default_nettype none

// Channel     Direction  Handshake                  Payload
// ---------   ---------  -------------------------  -------------------------------
// text in     input      i_in_valid / o_in_ready    i_text_byte, i_text_end
// match out   output     o_out_valid / i_out_ready  o_match_position
// registers   input      psel, penable, pwrite      paddr, pwdata -> prdata, pready
//
// One text byte per cycle while the match output is not stalled. A request waits
// in the input register, then the window compare and bad-symbol shift (parallel
// byte compares plus a last-occurrence priority pick) resolve into the result
// register when the compute stage advances.
// Reset (synchronous, active low) clears the pattern registers, the countdown,
// the position and the empty-pattern flag. A full result register stalls the
// compute stage; the input register still takes a request while it is empty.

module horspool_string_match
    import hsm_pkg::*;
#(
    parameter int PATTERN_MAX   = PATTERN_MAX_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // text in
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [7:0]        i_text_byte,
    input  wire logic              i_text_end,
    // match out
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic      [OUT_W-1:0]  o_match_position,
    // register port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int EXT_W = (POSITION_BITS + 1 > OUT_W) ? POSITION_BITS + 1 : OUT_W;
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    t_cfg     cfg;
    t_pattern pattern;

    hsm_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_cfg     (cfg),
        .o_pattern (pattern)
    );

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;

    // Text state
    logic [7:0]               r_win [PATTERN_MAX];
    logic [LEN_W-1:0]         r_cnt;
    logic [POSITION_BITS-1:0] r_pos;
    logic                     r_empty_done;

    // Result register
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_pos;

    // Next values
    logic [7:0]               n_win [PATTERN_MAX];
    logic [LEN_W-1:0]         n_cnt;
    logic [POSITION_BITS-1:0] n_pos;
    logic                     n_empty_done;
    logic                     n_out_valid;
    logic [OUT_W-1:0]         n_out_pos;

    logic             fire;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] new_len;
    logic             hit;
    logic [LEN_W-1:0] shift;
    logic [EXT_W-1:0] idx_next;
    logic [EXT_W-1:0] offset;

    // Clamp lengths beyond the window to the window size
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_CFG_W-1:0] l);
        logic [LEN_W-1:0] res;
        if (l > LEN_CFG_W'(PATTERN_MAX)) begin
            res = LEN_W'(PATTERN_MAX);
        end else begin
            res = LEN_W'(l);
        end
        return res;
    endfunction

    assign len     = clamp_len(cfg.length);
    assign new_len = clamp_len(cfg.new_length);

    // Compute stage advances when the result register is free or draining
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    // Window after this byte shifts in: oldest byte at index 0
    always_comb begin
        for (int j = 0; j < PATTERN_MAX - 1; j++) begin
            n_win[j] = r_win[j + 1];
        end
        n_win[PATTERN_MAX-1] = r_in_byte;
    end

    // Compare the newest len bytes of the window with pattern bytes 0..len-1
    always_comb begin
        int k;
        hit = 1'b1;
        for (int j = 0; j < PATTERN_MAX; j++) begin
            k = j + int'(len) - PATTERN_MAX;
            if (k >= 0) begin
                if (n_win[j] != pattern[k[PAT_IDX_W-1:0]]) begin
                    hit = 1'b0;
                end
            end
        end
    end

    // Bad-symbol shift: the last occurrence among bytes 0..len-2 wins
    always_comb begin
        shift = len;
        for (int i = 0; i < PATTERN_MAX - 1; i++) begin
            if (((LEN_W+1)'(i + 1) < {1'b0, len}) && (pattern[i] == r_in_byte)) begin
                shift = len - LEN_W'(1) - LEN_W'(i);
            end
        end
    end

    // Alignment start offset; also flags alignments that begin before the text
    assign idx_next = EXT_W'(r_pos) + EXT_W'(1);
    assign offset   = idx_next - EXT_W'(len);

    always_comb begin
        n_cnt        = r_cnt;
        n_pos        = r_pos;
        n_empty_done = r_empty_done;
        n_out_pos    = r_out_pos;
        n_out_valid  = r_out_valid && !i_out_ready;

        priority if (cfg.restart) begin
            // Length write: restart the text
            n_cnt        = new_len;
            n_pos        = '0;
            n_empty_done = 1'b0;
        end else if (fire) begin
            n_out_valid = 1'b0;
            if (r_pos != POS_MAX) begin
                n_pos = r_pos + POSITION_BITS'(1);
            end

            priority if (len == '0) begin
                // Empty pattern: report offset 0 once per text
                if (!r_empty_done) begin
                    n_out_valid  = 1'b1;
                    n_out_pos    = '0;
                    n_empty_done = 1'b1;
                end
            end else if (r_cnt > LEN_W'(1)) begin
                n_cnt = r_cnt - LEN_W'(1);
            end else if (idx_next < EXT_W'(len)) begin
                // Alignment would start before the text: skip the check
                n_cnt = len;
            end else begin
                if (hit) begin
                    n_out_valid = 1'b1;
                    n_out_pos   = offset[OUT_W-1:0];
                end
                n_cnt = shift;
            end

            // Last byte of the text: restart after its check
            if (r_in_end) begin
                n_cnt        = len;
                n_pos        = '0;
                n_empty_done = 1'b0;
            end
        end else begin
            // hold
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_cnt        <= '0;
            r_pos        <= '0;
            r_empty_done <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            r_out_valid  <= n_out_valid;
            r_cnt        <= n_cnt;
            r_pos        <= n_pos;
            r_empty_done <= n_empty_done;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_text_byte;
            r_in_end  <= i_text_end;
        end
        if (fire) begin
            for (int j = 0; j < PATTERN_MAX; j++) begin
                r_win[j] <= n_win[j];
            end
        end
        r_out_pos <= n_out_pos;
    end

    assign o_out_valid      = r_out_valid;
    assign o_match_position = r_out_pos;

endmodule

`default_nettype wire
